### rtl/core/chained_hash_table_defines.svh
// Assertion shorthands for the chained hash table checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CHT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cht_pkg.sv
package cht_pkg;

    localparam int DEF_NUM_BUCKETS  = 64;
    localparam int DEF_BUCKET_DEPTH = 16;
    localparam int DEF_KEY_BITS     = 32;

    localparam int KEY_PORT_W = 32;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_W    = 11;
    localparam int STATUS_W   = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic mod_step;
        logic fill_rd;
        logic scan_start;
        logic scan;
        logic commit;
    } cht_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic scan_done;
    } cht_stat_t;

endpackage

### rtl/core/chained_hash_table.sv
// After a start transfer the key is reduced to a bucket index by quotient, difference and
// correction steps, the fill count of the bucket is read, then its slots are read one a cycle
// until a key matches or every filled slot is compared; the result commits and done rises.
// A new start is taken in the cycle the done strobe is high. After reset, busy stays high
// while the bucket fill counts are cleared. done is high for one cycle only, while status and
// value_out hold until the next result; the receiver cannot stall the block.
module chained_hash_table #(
    parameter int NUM_BUCKETS  = cht_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = cht_pkg::DEF_BUCKET_DEPTH,
    parameter int KEY_BITS     = cht_pkg::DEF_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [cht_pkg::KEY_PORT_W-1:0]  key,
    input  logic [cht_pkg::VALUE_W-1:0]     value,
    output logic                            done,
    output logic [cht_pkg::STATUS_W-1:0]    status,
    output logic [cht_pkg::VALUE_W-1:0]     value_out,
    output logic [cht_pkg::ENTRY_W-1:0]     entry_total
);

    cht_pkg::cht_cmd_t  cmd;
    cht_pkg::cht_stat_t stat;

    cht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    cht_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .KEY_BITS     (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .status      (status),
        .value_out   (value_out),
        .entry_total (entry_total)
    );

endmodule

### rtl/core/cht_ram.sv
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/cht_ctrl.sv
module cht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output cht_pkg::cht_cmd_t   cmd,
    input  cht_pkg::cht_stat_t  stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_FILL,
        S_SCAN_START,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:      if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:       if (start) state_next = S_MOD;
            S_MOD:        if (stat.mod_last) state_next = S_FILL;
            S_FILL:       state_next = S_SCAN_START;
            S_SCAN_START: state_next = S_SCAN;
            S_SCAN:       if (stat.scan_done) state_next = S_COMMIT;
            S_COMMIT:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.clear      = (state_reg == S_CLEAR);
        cmd.load       = (state_reg == S_IDLE) && start;
        cmd.mod_step   = (state_reg == S_MOD);
        cmd.fill_rd    = (state_reg == S_FILL);
        cmd.scan_start = (state_reg == S_SCAN_START);
        cmd.scan       = (state_reg == S_SCAN);
        cmd.commit     = (state_reg == S_COMMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_reg == S_COMMIT);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### rtl/core/cht_dp.sv
module cht_dp #(
    parameter int NUM_BUCKETS  = cht_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = cht_pkg::DEF_BUCKET_DEPTH,
    parameter int KEY_BITS     = cht_pkg::DEF_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cht_pkg::cht_cmd_t               cmd,
    output cht_pkg::cht_stat_t              stat,
    input  logic                            operation,
    input  logic [cht_pkg::KEY_PORT_W-1:0]  key,
    input  logic [cht_pkg::VALUE_W-1:0]     value,
    output logic [cht_pkg::STATUS_W-1:0]    status,
    output logic [cht_pkg::VALUE_W-1:0]     value_out,
    output logic [cht_pkg::ENTRY_W-1:0]     entry_total
);

    localparam int KEY_W   = (KEY_BITS < cht_pkg::KEY_PORT_W) ? KEY_BITS : cht_pkg::KEY_PORT_W;
    localparam int KP_W    = cht_pkg::KEY_PORT_W;
    localparam int MOD_STEPS = 3;
    localparam int STEP_W  = 2;
    localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int RECIP_SH = KP_W - 1 + $clog2(NUM_BUCKETS);
    localparam logic [2*KP_W-1:0] RECIP_WIDE =
        ((2*KP_W)'(1) << RECIP_SH) / (2*KP_W)'(NUM_BUCKETS);
    localparam logic [KP_W-1:0] RECIP = RECIP_WIDE[KP_W-1:0];
    localparam logic [BKT_W:0] NB = (BKT_W + 1)'(NUM_BUCKETS);

    logic                           op_reg;
    logic [KEY_W-1:0]               key_reg;
    logic [cht_pkg::VALUE_W-1:0]    val_reg;
    logic [KP_W-1:0]                quot_reg;
    logic [BKT_W:0]                 diff_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [BKT_W-1:0]               rem_reg;
    logic [SLOT_AW-1:0]             base_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              idx_reg;
    logic                           pend_reg;
    logic [FILL_W-1:0]              pend_idx_reg;
    logic                           found_reg;
    logic [FILL_W-1:0]              pos_reg;
    logic [cht_pkg::VALUE_W-1:0]    hit_val_reg;
    logic [BKT_W-1:0]               clr_reg;
    logic [cht_pkg::ENTRY_W-1:0]    count_reg;
    cht_pkg::status_t               status_reg;
    cht_pkg::status_t               status_next;
    logic [cht_pkg::VALUE_W-1:0]    vout_reg;
    logic [cht_pkg::VALUE_W-1:0]    vout_next;

    logic [KP_W-1:0]                key_ext;
    logic [2*KP_W-1:0]              prod_full;
    logic [2*KP_W-1:0]              prod_shift;
    logic [KP_W-1:0]                diff_full;
    logic [BKT_W:0]                 rem_fix;
    logic                           issue_ok;
    logic                           hit_now;
    logic                           bucket_full;
    logic                           do_append;
    logic                           do_replace;
    logic [FILL_W-1:0]              wr_pos;
    logic [SLOT_AW-1:0]             slot_raddr;
    logic [SLOT_AW-1:0]             slot_waddr;
    logic [KEY_W-1:0]               key_rdata;
    logic [cht_pkg::VALUE_W-1:0]    val_rdata;
    logic [FILL_W-1:0]              fill_rdata;
    logic                           fill_we;
    logic [BKT_W-1:0]               fill_waddr;
    logic [FILL_W-1:0]              fill_wdata;

    // Remainder by the bucket count: the reciprocal estimate of the quotient is exact or
    // one short, so a single conditional subtract of the bucket count finishes it.
    assign key_ext    = KP_W'(key_reg);
    assign prod_full  = (2*KP_W)'(key_ext) * (2*KP_W)'(RECIP);
    assign prod_shift = prod_full >> RECIP_SH;
    assign diff_full  = key_ext - quot_reg * KP_W'(NUM_BUCKETS);
    assign rem_fix    = (diff_reg >= NB) ? diff_reg - NB : diff_reg;

    assign issue_ok    = (idx_reg < fill_reg);
    assign hit_now     = pend_reg && (key_rdata == key_reg);
    assign bucket_full = (fill_reg == FILL_W'(BUCKET_DEPTH));
    assign do_replace  = (op_reg == cht_pkg::OP_INSERT) && found_reg;
    assign do_append   = (op_reg == cht_pkg::OP_INSERT) && !found_reg && !bucket_full;
    assign wr_pos      = found_reg ? pos_reg : fill_reg;
    assign slot_raddr  = base_reg + SLOT_AW'(idx_reg);
    assign slot_waddr  = base_reg + SLOT_AW'(wr_pos);

    assign stat.clr_last  = (clr_reg == BKT_W'(NUM_BUCKETS - 1));
    assign stat.mod_last  = (step_reg == STEP_W'(MOD_STEPS - 1));
    assign stat.scan_done = hit_now || (!pend_reg && !issue_ok);

    always_comb
    begin
        fill_we    = 1'b0;
        fill_waddr = rem_reg;
        fill_wdata = fill_reg + 1'b1;
        if (cmd.clear)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_reg;
            fill_wdata = '0;
        end
        else if (cmd.commit && do_append)
        begin
            fill_we = 1'b1;
        end
    end

    always_comb
    begin
        vout_next = '0;
        if (op_reg == cht_pkg::OP_LOOKUP)
        begin
            if (found_reg)
            begin
                status_next = cht_pkg::ST_HIT;
                vout_next   = hit_val_reg;
            end
            else
            begin
                status_next = cht_pkg::ST_MISS;
            end
        end
        else if (found_reg)
        begin
            status_next = cht_pkg::ST_REPLACED;
        end
        else if (bucket_full)
        begin
            status_next = cht_pkg::ST_DROPPED;
        end
        else
        begin
            status_next = cht_pkg::ST_INSERTED;
        end
    end

    cht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (cmd.commit && do_append),
        .waddr (slot_waddr),
        .wdata (key_reg),
        .raddr (slot_raddr),
        .rdata (key_rdata)
    );

    cht_ram #(.WIDTH(cht_pkg::VALUE_W), .DEPTH(SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (cmd.commit && (do_append || do_replace)),
        .waddr (slot_waddr),
        .wdata (val_reg),
        .raddr (slot_raddr),
        .rdata (val_rdata)
    );

    cht_ram #(.WIDTH(FILL_W), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (rem_reg),
        .rdata (fill_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= issue_ok && !hit_now;
                if (hit_now)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit && do_append)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            key_reg   <= key[KEY_W-1:0];
            val_reg   <= value;
            step_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            // Quotient, difference and correction form a three-stage pipe; the bucket
            // index in rem_reg is valid once each stage has run in turn.
            quot_reg  <= prod_shift[KP_W-1:0];
            diff_reg  <= diff_full[BKT_W:0];
            rem_reg   <= rem_fix[BKT_W-1:0];
            step_reg  <= step_reg + 1'b1;
        end
        if (cmd.fill_rd)
        begin
            base_reg <= SLOT_AW'(rem_reg) * SLOT_AW'(BUCKET_DEPTH);
        end
        if (cmd.scan_start)
        begin
            fill_reg <= fill_rdata;
            idx_reg  <= '0;
        end
        if (cmd.scan)
        begin
            // One slot read per cycle until a hit; its key is compared the cycle after.
            if (issue_ok && !hit_now)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            pend_idx_reg <= idx_reg;
            if (hit_now)
            begin
                pos_reg     <= pend_idx_reg;
                hit_val_reg <= val_rdata;
            end
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
        end
    end

    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_total = count_reg;

endmodule

### rtl/core/cht_checker.sv
`include "chained_hash_table_defines.svh"

module cht_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [cht_pkg::STATUS_W-1:0]    status,
    input logic [cht_pkg::VALUE_W-1:0]     value_out,
    input logic [cht_pkg::ENTRY_W-1:0]     entry_total
);

    `CHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")

    `CHT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")

    `CHT_ASSERT_NOW(a_value_zero, done && (status != cht_pkg::ST_HIT), value_out == '0, "value_out not zero without a hit")

    `CHT_ASSERT_NOW(a_count_inc, done && (status == cht_pkg::ST_INSERTED), entry_total == $past(entry_total) + 1'b1, "insert did not raise the entry count by one")

    `CHT_ASSERT_NOW(a_count_hold, done && (status != cht_pkg::ST_INSERTED), $stable(entry_total), "entry count changed without an insert")

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_total (entry_total)
);

### tb/sv/tb_chained_hash_table.sv
module tb_chained_hash_table;

    localparam int NB = cht_pkg::DEF_NUM_BUCKETS;
    localparam int BD = cht_pkg::DEF_BUCKET_DEPTH;
    localparam int KW = cht_pkg::KEY_PORT_W;
    localparam int VW = cht_pkg::VALUE_W;
    localparam int EW = cht_pkg::ENTRY_W;
    localparam int SW = cht_pkg::STATUS_W;
    localparam int RANDOM_ITEMS = 2000;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        cht_pkg::status_t   status;
        logic [VW-1:0]      value_out;
        logic [EW-1:0]      entry_total;
    } table_reply_t;

    class hash_table_scoreboard;
        logic [KW-1:0]  slot_key [NB][BD];
        logic [VW-1:0]  slot_value [NB][BD];
        int unsigned    bucket_used [NB];
        int unsigned    keys_held;
        table_reply_t   replies [$];
        int unsigned    error_count;

        function new();
            keys_held   = 0;
            error_count = 0;
            foreach (bucket_used[b])
                bucket_used[b] = 0;
        endfunction

        // Applies one accepted request to the shadow table and queues its reply.
        function void note_request(logic op, logic [KW-1:0] k, logic [VW-1:0] v);
            int unsigned  b;
            int unsigned  i;
            int           pos;
            table_reply_t r;
            b   = k % NB;
            pos = -1;
            for (i = 0; i < bucket_used[b]; i++)
                if (pos < 0 && slot_key[b][i] == k)
                    pos = i;
            r.value_out = '0;
            if (op == cht_pkg::OP_INSERT)
            begin
                if (pos >= 0)
                begin
                    slot_value[b][pos] = v;
                    r.status = cht_pkg::ST_REPLACED;
                end
                else if (bucket_used[b] >= BD)
                begin
                    r.status = cht_pkg::ST_DROPPED;
                end
                else
                begin
                    slot_key[b][bucket_used[b]]   = k;
                    slot_value[b][bucket_used[b]] = v;
                    bucket_used[b]++;
                    keys_held++;
                    r.status = cht_pkg::ST_INSERTED;
                end
            end
            else if (pos >= 0)
            begin
                r.value_out = slot_value[b][pos];
                r.status    = cht_pkg::ST_HIT;
            end
            else
            begin
                r.status = cht_pkg::ST_MISS;
            end
            r.entry_total = keys_held[EW-1:0];
            replies.push_back(r);
        endfunction

        function void check_result(logic [SW-1:0] st, logic [VW-1:0] vo, logic [EW-1:0] et);
            table_reply_t r;
            if (replies.size() == 0)
            begin
                $error("result with no request pending: status %0d, value_out %h", st, vo);
                error_count++;
                return;
            end
            r = replies.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, st);
                error_count++;
            end
            if (vo !== r.value_out)
            begin
                $error("value_out: expected %h, actual %h", r.value_out, vo);
                error_count++;
            end
            if (et !== r.entry_total)
            begin
                $error("entry_total: expected %0d, actual %0d", r.entry_total, et);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return replies.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               operation = cht_pkg::OP_INSERT;
    logic [KW-1:0]      key = '0;
    logic [VW-1:0]      value = '0;
    logic               done;
    logic [SW-1:0]      status;
    logic [VW-1:0]      value_out;
    logic [EW-1:0]      entry_total;

    hash_table_scoreboard   sb = new();
    logic [KW-1:0]          used_keys [$];
    int                     burst_left = 1;
    int unsigned            cycle_count = 0;

    chained_hash_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .value_out   (value_out),
        .entry_total (entry_total)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(status, value_out, entry_total);

    // Holds start high until the transfer is taken; start is lowered only when a gap follows.
    task automatic issue(logic op, logic [KW-1:0] k, logic [VW-1:0] v);
        int idle;
        start     <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, k, v);
        if (op == cht_pkg::OP_INSERT)
            used_keys.push_back(k);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (idle > 0)
            begin
                start <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    endtask

    // Mixes keys already seen, keys crowded into a few buckets, and fully random keys.
    function automatic logic [KW-1:0] pick_key();
        logic [KW-1:0] k;
        int            sel;
        sel = $urandom_range(0, 99);
        k   = $urandom();
        if (sel < 35 && used_keys.size() > 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel < 70)
            k[5:0] = 6'($urandom_range(0, 7));
        return k;
    endfunction

    function automatic logic [VW-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom();
    endfunction

    initial
    begin
        int i;
        logic op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Lookup on an empty table, then fill one bucket to its depth.
        issue(cht_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        for (i = 0; i < BD; i++)
            issue(cht_pkg::OP_INSERT, 32'hFFFF_FC05 - (i << 6),
                  (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom());
        issue(cht_pkg::OP_INSERT, 32'h0000_0005, 32'h1234_5678);
        issue(cht_pkg::OP_INSERT, 32'hFFFF_FC05 - (3 << 6), 32'hA5A5_5A5A);
        issue(cht_pkg::OP_LOOKUP, 32'hFFFF_FC05 - (3 << 6), 32'h0);
        issue(cht_pkg::OP_LOOKUP, 32'hFFFF_FC05 - ((BD - 1) << 6), 32'h0);
        issue(cht_pkg::OP_LOOKUP, 32'h0000_0005, 32'h0);
        issue(cht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(cht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(cht_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = ($urandom_range(0, 99) < 40) ? cht_pkg::OP_LOOKUP : cht_pkg::OP_INSERT;
            issue(op, pick_key(), pick_value());
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/cht_pkg.sv
rtl/core/cht_ram.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dp.sv
rtl/core/chained_hash_table.sv
rtl/core/cht_checker.sv
tb/sv/tb_chained_hash_table.sv
